// ===== rtl/core/sdm_pkg.sv =====
// ----------------------------------------------------------------------------
// sdm_pkg
// Types and constants shared by the service day mask unit.
// ----------------------------------------------------------------------------
package sdm_pkg;

  // Operation codes carried on the action port.
  typedef enum logic [1:0] {
    ACT_BUILD  = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_SHIFT  = 2'd3
  } action_t;

  localparam int unsigned MASK_W      = 64;
  localparam int unsigned DAY_W       = 16;
  localparam int unsigned TILE_W      = 15;
  localparam int unsigned WEEK_DAYS   = 7;
  // Internal signed day arithmetic: room for tile_offset plus the window length.
  localparam int unsigned CALC_W      = 18;
  localparam logic [2:0]  PIVOT_RESET = 3'd3;

  // Rotate a weekday mask right by wd days (wd in 0..6).
  function automatic logic [WEEK_DAYS-1:0] rotate_week(input logic [WEEK_DAYS-1:0] m,
                                                       input logic [2:0] wd);
    logic [2*WEEK_DAYS-1:0] dbl;
    dbl = {m, m} >> wd;
    return dbl[WEEK_DAYS-1:0];
  endfunction

  // (pivot + tile) mod 7 by folding octal digits, since 8 is 1 mod 7.
  function automatic logic [2:0] window_weekday(input logic [2:0] pivot,
                                                input logic [TILE_W-1:0] tile);
    logic [5:0] sum1;
    logic [3:0] sum2;
    sum1 = 6'(pivot) + 6'(tile[2:0]) + 6'(tile[5:3]) + 6'(tile[8:6])
         + 6'(tile[11:9]) + 6'(tile[14:12]);
    sum2 = 4'(sum1[5:3]) + 4'(sum1[2:0]);
    if (sum2 >= 4'(WEEK_DAYS)) begin
      sum2 = sum2 - 4'(WEEK_DAYS);
    end
    return sum2[2:0];
  endfunction

endpackage

// ===== rtl/core/service_day_mask_unit.sv =====
// ----------------------------------------------------------------------------
// service_day_mask_unit
// Builds and edits a day-of-service bitmask over a window of WINDOW_DAYS days.
// ----------------------------------------------------------------------------
//
// Channel      Handshake                Payload
// -----------  -----------------------  ---------------------------------------
// command      start, busy              action, tile_offset, service_start,
//                                       service_end, weekday_mask, edit_day,
//                                       mask_in
// result       done (one-cycle strobe)  mask_out, clamped_start, clamped_end
// config       cfg_valid, cfg_ready     cfg_data (pivot weekday)
//
// A command transaction completes on a clock edge where start is high and busy
// is low. Busy is never asserted, so one command can be taken every cycle.
// Each command yields one result: the command is captured in an input
// register, and one pass of combinational logic fills the result register,
// whose contents are shown with done for exactly one cycle. The receiver cannot
// stall, so nothing ever backs up. Synchronous reset clears the pipeline valid
// flags and sets the pivot weekday to Wednesday (3).
// The config channel is always ready; writes belong to idle periods.
//
// Bit i of every mask stands for day tile_offset + i, counted from the pivot.
// ----------------------------------------------------------------------------
module service_day_mask_unit #(
  parameter int unsigned WINDOW_DAYS = 60
) (
  input  logic                       clk,
  input  logic                       rst,
  // Command transaction.
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 action,
  input  logic [14:0]                tile_offset,
  input  logic signed [15:0]         service_start,
  input  logic signed [15:0]         service_end,
  input  logic [6:0]                 weekday_mask,
  input  logic signed [15:0]         edit_day,
  input  logic [63:0]                mask_in,
  // Result transaction.
  output logic                       done,
  output logic [63:0]                mask_out,
  output logic signed [15:0]         clamped_start,
  output logic signed [15:0]         clamped_end,
  // Configuration write.
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_data
);

  localparam int unsigned IDX_W = (WINDOW_DAYS > 1) ? $clog2(WINDOW_DAYS) : 1;
  localparam int unsigned CW    = sdm_pkg::CALC_W;
  localparam int unsigned MW    = sdm_pkg::MASK_W;
  localparam int unsigned REPS  = (MW + sdm_pkg::WEEK_DAYS - 1) / sdm_pkg::WEEK_DAYS;

  // The unit never holds off a command or a configuration write.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Pivot weekday register.
  logic [2:0] pivot_weekday;

  always_ff @(posedge clk) begin
    if (rst) begin
      pivot_weekday <= sdm_pkg::PIVOT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pivot_weekday <= cfg_data;
    end
  end

  // Input register stage.
  logic                in_valid;
  sdm_pkg::action_t    in_action;
  logic [14:0]         in_tile;
  logic signed [15:0]  in_start;
  logic signed [15:0]  in_end;
  logic [6:0]          in_wmask;
  logic signed [15:0]  in_eday;
  logic [63:0]         in_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_action <= sdm_pkg::action_t'(action);
      in_tile   <= tile_offset;
      in_start  <= service_start;
      in_end    <= service_end;
      in_wmask  <= weekday_mask;
      in_eday   <= edit_day;
      in_mask   <= mask_in;
    end
  end

  // Day arithmetic at a common width: tile_offset zero-extended, the rest sign-extended.
  logic signed [CW-1:0] tile_s;
  logic signed [CW-1:0] last_s;
  logic signed [CW-1:0] start_s;
  logic signed [CW-1:0] end_s;
  logic signed [CW-1:0] eday_s;
  logic signed [CW-1:0] cs_s;
  logic signed [CW-1:0] ce_s;
  logic signed [CW-1:0] hi_s;
  logic signed [CW-1:0] total_s;
  logic signed [CW-1:0] before_s;
  logic signed [CW-1:0] eoff_s;
  logic                 build_ok;
  logic                 edit_ok;
  logic [IDX_W-1:0]     total_idx;
  logic [IDX_W-1:0]     before_idx;
  logic [IDX_W-1:0]     edit_idx;
  logic [2:0]           wd;
  logic [6:0]           rot;
  logic [REPS*7-1:0]    weekly;
  logic [MW-1:0]        build_mask;
  logic [MW-1:0]        edit_bit;
  logic [MW-1:0]        shift_mask;

  logic [63:0]          mask_out_next;
  logic signed [15:0]   clamped_start_next;
  logic signed [15:0]   clamped_end_next;

  always_comb begin
    tile_s  = $signed({{(CW - 15){1'b0}}, in_tile});
    last_s  = tile_s + CW'(WINDOW_DAYS - 1);
    start_s = CW'(in_start);
    end_s   = CW'(in_end);
    eday_s  = CW'(in_eday);

    // A build is rejected when the service lies wholly outside the window.
    build_ok = (start_s <= last_s) && (tile_s <= end_s);
    cs_s     = (start_s < tile_s) ? tile_s : start_s;
    ce_s     = (end_s > last_s) ? last_s : end_s;
    total_s  = ce_s - tile_s;
    before_s = cs_s - tile_s;
    total_idx  = total_s[IDX_W-1:0];
    before_idx = before_s[IDX_W-1:0];

    // Weekday pattern aligned to the window start and repeated weekly.
    wd     = sdm_pkg::window_weekday(pivot_weekday, in_tile);
    rot    = sdm_pkg::rotate_week(in_wmask, wd);
    weekly = {REPS{rot}};

    // Edits touch only a day inside the window and not past the service end.
    hi_s     = (last_s < end_s) ? last_s : end_s;
    edit_ok  = (tile_s <= eday_s) && (eday_s <= hi_s);
    eoff_s   = eday_s - tile_s;
    edit_idx = eoff_s[IDX_W-1:0];

    for (int i = 0; i < MW; i++) begin
      if (i < WINDOW_DAYS) begin
        build_mask[i] = weekly[i] && (IDX_W'(i) >= before_idx) && (IDX_W'(i) <= total_idx);
        edit_bit[i]   = edit_ok && (IDX_W'(i) == edit_idx);
      end else begin
        build_mask[i] = 1'b0;
        edit_bit[i]   = 1'b0;
      end
    end

    // Shift drops whatever lands on the first day past the window.
    shift_mask = in_mask << 1;
    if (WINDOW_DAYS < MW) begin
      shift_mask[WINDOW_DAYS[$clog2(MW)-1:0]] = 1'b0;
    end

    mask_out_next      = '0;
    clamped_start_next = '0;
    clamped_end_next   = '0;
    unique case (in_action)
      sdm_pkg::ACT_BUILD: begin
        if (build_ok) begin
          mask_out_next      = build_mask;
          clamped_start_next = cs_s[15:0];
          clamped_end_next   = ce_s[15:0];
        end else begin
          clamped_start_next = in_start;
          clamped_end_next   = in_end;
        end
      end
      sdm_pkg::ACT_ADD: begin
        mask_out_next = in_mask | edit_bit;
      end
      sdm_pkg::ACT_REMOVE: begin
        mask_out_next = in_mask & ~edit_bit;
      end
      sdm_pkg::ACT_SHIFT: begin
        mask_out_next = shift_mask;
      end
      default: begin
        mask_out_next = in_mask;
      end
    endcase
  end

  // Result register: shown with done for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      mask_out      <= mask_out_next;
      clamped_start <= clamped_start_next;
      clamped_end   <= clamped_end_next;
    end
  end

endmodule
